// File: rtl/bdda_pkg.sv
// Shared types, constants and calendar helpers for the business-day date adder.
// No dependencies; imported by every module of the block.
`default_nettype none

package bdda_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_DATE    = 2'd1,
		ST_ALL_WEEKEND = 2'd2,
		ST_YEAR_OVF    = 2'd3
	} status_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		WK_IDLE,
		WK_STEP,
		WK_DONE
	} walk_state_t;

	localparam logic [13:0] YEAR_MAX     = 14'd9999;
	localparam logic [3:0]  MONTH_DEC    = 4'd12;
	localparam logic [3:0]  MONTH_FEB    = 4'd2;
	localparam logic [2:0]  WEEKDAY_LAST = 3'd6;
	localparam logic [6:0]  YMOD_LAST    = 7'd99;

	// One classified job handed from the front end to the walker
	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [14:0] work_days;
		logic [2:0]  weekday;
		logic [6:0]  year_mod100;
		logic [1:0]  cent_mod4;
		status_t     status;
	} job_t;

	// Gregorian leap rule from the year's residues
	function automatic logic is_leap(input logic [1:0] y_mod4, input logic [6:0] y_mod100,
			input logic [1:0] cent_mod4);
		if (y_mod100 != 7'd0)
			return (y_mod4 == 2'd0);
		return (cent_mod4 == 2'd0);
	endfunction

	// Days in month; zero for a month code outside 1..12
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			MONTH_FEB:                   len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7,
			4'd8, 4'd10, MONTH_DEC:      len = 5'd31;
			default:                     len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// File: rtl/bdda_front.sv
// Front end: takes a request, checks the start date and finds its weekday.
// Three register stages; depends on bdda_pkg.
`default_nettype none

module bdda_front import bdda_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [4:0]  start_day,
	input  wire logic [3:0]  start_month,
	input  wire logic [13:0] start_year,
	input  wire logic [14:0] work_days,
	input  wire logic [6:0]  weekend_mask,
	input  wire logic        q_full,
	output logic             busy,
	output logic             push,
	output job_t             push_job
);

	// (31 * mm) / 12 term of the weekday formula, indexed by month
	function automatic logic [4:0] month_term(input logic [3:0] m);
		logic [4:0] t;
		case (m)
			4'd1:    t = 5'd28;
			4'd2:    t = 5'd31;
			4'd3:    t = 5'd2;
			4'd4:    t = 5'd5;
			4'd5:    t = 5'd7;
			4'd6:    t = 5'd10;
			4'd7:    t = 5'd12;
			4'd8:    t = 5'd15;
			4'd9:    t = 5'd18;
			4'd10:   t = 5'd20;
			4'd11:   t = 5'd23;
			4'd12:   t = 5'd25;
			default: t = 5'd0;
		endcase
		return t;
	endfunction

	// x mod 7 by folding 3-bit digits (8 = 1 mod 7)
	function automatic logic [2:0] mod7(input logic [14:0] x);
		logic [5:0] f1;
		logic [3:0] f2;
		f1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
		f2 = 4'(f1[5:3]) + 4'(f1[2:0]);
		if (f2 >= 4'd7)
			f2 = f2 - 4'd7;
		return f2[2:0];
	endfunction

	logic        accept;
	logic        v_s1, v_s2, v_s3;
	logic [4:0]  d_s1, d_s2, d_s3;
	logic [3:0]  m_s1, m_s2, m_s3;
	logic [13:0] y_s1, y_s2, y_s3;
	logic [14:0] n_s1, n_s2, n_s3;
	logic [7:0]  cent_s2;
	logic [6:0]  rem_s2, rem_s3;
	logic [1:0]  cent4_s3;
	status_t     status_s3;
	logic [14:0] sum_s3;

	logic [26:0] cent_prod;
	logic [7:0]  cent;
	logic [13:0] rem_full;
	logic        leap;
	logic [4:0]  mlen;
	logic        date_ok;
	logic        all_weekend;
	status_t     status_c;
	logic        early;
	logic [13:0] yy;
	logic [7:0]  qq;
	logic [14:0] wd_sum;

	// One item in the front at a time; the queue always has room for it
	assign busy   = v_s1 | v_s2 | v_s3 | q_full;
	assign accept = start & ~busy;

	// Stage 1 -> 2: century and year-in-century by reciprocal multiply
	always_comb begin
		cent_prod = 27'(y_s1) * 27'd5243;
		cent      = cent_prod[26:19];
		rem_full  = y_s1 - 14'(15'(cent) * 15'd100);
	end

	// Stage 2 -> 3: validity, classification and weekday sum
	always_comb begin
		leap        = is_leap(y_s2[1:0], rem_s2, cent_s2[1:0]);
		mlen        = month_len(m_s2, leap);
		date_ok     = (m_s2 >= 4'd1) && (m_s2 <= MONTH_DEC) && (y_s2 >= 14'd1) &&
		              (y_s2 <= YEAR_MAX) && (d_s2 >= 5'd1) && (d_s2 <= mlen);
		all_weekend = (&weekend_mask) && (n_s2 != 15'd0);
		if (!date_ok)
			status_c = ST_BAD_DATE;
		else if (all_weekend)
			status_c = ST_ALL_WEEKEND;
		else
			status_c = ST_OK;
		early  = (m_s2 <= MONTH_FEB);
		yy     = y_s2 - 14'(early);
		qq     = (early && rem_s2 == 7'd0) ? cent_s2 - 8'd1 : cent_s2;
		wd_sum = 15'(d_s2) + 15'(yy) + 15'(yy[13:2]) - 15'(qq) + 15'(qq[7:2])
		         + 15'(month_term(m_s2));
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			d_s1 <= start_day;
			m_s1 <= start_month;
			y_s1 <= start_year;
			n_s1 <= work_days;
		end
		if (v_s1) begin
			d_s2    <= d_s1;
			m_s2    <= m_s1;
			y_s2    <= y_s1;
			n_s2    <= n_s1;
			cent_s2 <= cent;
			rem_s2  <= rem_full[6:0];
		end
		if (v_s2) begin
			d_s3      <= d_s2;
			m_s3      <= m_s2;
			y_s3      <= y_s2;
			n_s3      <= n_s2;
			rem_s3    <= rem_s2;
			cent4_s3  <= cent_s2[1:0];
			status_s3 <= status_c;
			sum_s3    <= wd_sum;
		end
	end

	// Stage 3: weekday and transfer into the queue
	always_comb begin
		push                 = v_s3;
		push_job.day         = d_s3;
		push_job.month       = m_s3;
		push_job.year        = y_s3;
		push_job.work_days   = n_s3;
		push_job.weekday     = mod7(sum_s3);
		push_job.year_mod100 = rem_s3;
		push_job.cent_mod4   = cent4_s3;
		push_job.status      = status_s3;
	end

endmodule

`default_nettype wire

// File: rtl/bdda_queue.sv
// Short job queue between the front end and the walker.
// Depends on bdda_pkg for the job type.
`default_nettype none

module bdda_queue import bdda_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	input  wire logic pop,
	output job_t      head,
	output logic      empty,
	output logic      full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == CNT_W'(0));
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue transfer while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue pop while empty");

endmodule

`default_nettype wire

// File: rtl/bdda_walker.sv
// Back end: walks the calendar one day per cycle and counts working days.
// Depends on bdda_pkg.
`default_nettype none

module bdda_walker import bdda_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [6:0]  weekend_mask,
	input  wire logic        q_empty,
	input  job_t             head,
	output logic             pop,
	output logic             done,
	output logic [4:0]       end_day,
	output logic [3:0]       end_month,
	output logic [13:0]      end_year,
	output logic [2:0]       end_weekday,
	output logic [1:0]       status
);

	walk_state_t state_q, state_d;
	logic [4:0]  d_q;
	logic [3:0]  m_q;
	logic [13:0] y_q;
	logic [2:0]  wd_q;
	logic [14:0] n_q, cnt_q;
	logic [6:0]  ymod_q;
	logic [1:0]  cent4_q;
	status_t     status_q;

	logic        step_en;
	logic        count_done;
	logic        leap;
	logic [4:0]  mlen;
	logic        month_end, year_end, overflow;
	logic        working;

	// Day-step decode
	always_comb begin
		count_done = (cnt_q == n_q);
		leap       = is_leap(y_q[1:0], ymod_q, cent4_q);
		mlen       = month_len(m_q, leap);
		month_end  = (d_q == mlen);
		year_end   = (m_q == MONTH_DEC);
		overflow   = month_end && year_end && (y_q == YEAR_MAX);
		working    = ~weekend_mask[wd_q];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			WK_IDLE: begin
				if (!q_empty)
					state_d = (head.status != ST_OK) ? WK_DONE : WK_STEP;
			end
			WK_STEP: begin
				if (count_done || overflow)
					state_d = WK_DONE;
			end
			WK_DONE: state_d = WK_IDLE;
			default: state_d = WK_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		pop     = 1'b0;
		done    = 1'b0;
		step_en = 1'b0;
		unique case (state_q)
			WK_IDLE: pop     = ~q_empty;
			WK_STEP: step_en = ~count_done;
			WK_DONE: done    = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= WK_IDLE;
		else
			state_q <= state_d;
	end

	// Date, weekday and count registers
	always_ff @(posedge clk) begin
		if (pop) begin
			d_q      <= head.day;
			m_q      <= head.month;
			y_q      <= head.year;
			wd_q     <= head.weekday;
			n_q      <= head.work_days;
			cnt_q    <= '0;
			ymod_q   <= head.year_mod100;
			cent4_q  <= head.cent_mod4;
			status_q <= head.status;
		end else if (step_en) begin
			cnt_q <= cnt_q + 15'(working);
			wd_q  <= (wd_q == WEEKDAY_LAST) ? 3'd0 : wd_q + 3'd1;
			if (overflow) begin
				status_q <= ST_YEAR_OVF;
			end else if (month_end) begin
				d_q <= 5'd1;
				if (year_end) begin
					m_q     <= 4'd1;
					y_q     <= y_q + 14'd1;
					ymod_q  <= (ymod_q == YMOD_LAST) ? 7'd0 : ymod_q + 7'd1;
					cent4_q <= cent4_q + 2'(ymod_q == YMOD_LAST);
				end else begin
					m_q <= m_q + 4'd1;
				end
			end else begin
				d_q <= d_q + 5'd1;
			end
		end
	end

	// Result ports; date fields read zero on any error
	always_comb begin
		end_day     = '0;
		end_month   = '0;
		end_year    = '0;
		end_weekday = '0;
		status      = ST_OK;
		if (done) begin
			status = status_q;
			if (status_q == ST_OK) begin
				end_day     = d_q;
				end_month   = m_q;
				end_year    = y_q;
				end_weekday = wd_q;
			end
		end
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe held longer than one cycle");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == WK_STEP) |-> (cnt_q <= n_q))
		else $error("working-day count ran past the request");
	a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q != WK_IDLE))
		else $error("job taken from queue but walker stayed idle");
	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == WK_STEP) |-> (wd_q <= WEEKDAY_LAST))
		else $error("weekday out of range during walk");

endmodule

`default_nettype wire

// File: rtl/business_day_date_adder_unit.sv
// Top level of the business-day date adder: config register, front end, queue, walker.
// Depends on bdda_pkg, bdda_front, bdda_queue and bdda_walker.
// Flow: the front stages, a load from the queue, the day-by-day walk and the result strobe, in
//   that order; a year overflow ends the walk, and an error skips the walk and goes to the strobe.
// Throughput is set by the walker, which steps one day per cycle; the front end holds one request
//   at a time but can take a new one while the walker works, if the queue has room. The receiver cannot stall.
// Reset clears all control state and sets weekend_mask to 96 (Friday and Saturday).
`default_nettype none

module business_day_date_adder_unit import bdda_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request
	input  wire logic        start,
	output logic             busy,
	input  wire logic [4:0]  start_day,
	input  wire logic [3:0]  start_month,
	input  wire logic [13:0] start_year,
	input  wire logic [14:0] work_days,
	// result
	output logic             done,
	output logic [4:0]       end_day,
	output logic [3:0]       end_month,
	output logic [13:0]      end_year,
	output logic [2:0]       end_weekday,
	output logic [1:0]       status,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [6:0] weekend_mask_q;
	logic       cfg_wr;
	logic       q_push, q_pop, q_empty, q_full;
	job_t       q_in, q_head;

	// Configuration register at byte address 0
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {25'd0, weekend_mask_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			weekend_mask_q <= 7'd96;
		else if (cfg_wr)
			weekend_mask_q <= pwdata[6:0];
	end

	bdda_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.start_day    (start_day),
		.start_month  (start_month),
		.start_year   (start_year),
		.work_days    (work_days),
		.weekend_mask (weekend_mask_q),
		.q_full       (q_full),
		.busy         (busy),
		.push         (q_push),
		.push_job     (q_in)
	);

	bdda_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_in),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	bdda_walker u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.weekend_mask (weekend_mask_q),
		.q_empty      (q_empty),
		.head         (q_head),
		.pop          (q_pop),
		.done         (done),
		.end_day      (end_day),
		.end_month    (end_month),
		.end_year     (end_year),
		.end_weekday  (end_weekday),
		.status       (status)
	);

	a_mask_stable_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !$past(cfg_wr)) |-> $stable(weekend_mask_q))
		else $error("weekend mask changed as a result was delivered");

endmodule

`default_nettype wire
